>>> hdl/crtstg_pkg.sv
// ----------------------------------------------------------------------------
// CRT sync timing generator package
// Register map indexes, sync modes, line regions and register reset values.
// ----------------------------------------------------------------------------
package crtstg_pkg;

    // Register indexes on the configuration port (byte address = 4 * index).
    typedef enum logic [2:0] {
        REG_H_TOTAL       = 3'd0,
        REG_H_SYNC_WIDTH  = 3'd1,
        REG_V_SYNC_WIDTH  = 3'd2,
        REG_V_BP_LINES    = 3'd3,
        REG_V_VISIBLE     = 3'd4,
        REG_V_FP_LINES    = 3'd5,
        REG_SYNC_MODE     = 3'd6,
        REG_SYNC_POLARITY = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        SYNC_SEPARATE  = 2'd0,
        SYNC_COMP_XOR  = 2'd1,
        SYNC_COMP_AND  = 2'd2,
        SYNC_DISABLED  = 2'd3
    } t_sync_mode;

    typedef enum logic [1:0] {
        REGION_VSYNC       = 2'd0,
        REGION_BACK_PORCH  = 2'd1,
        REGION_VISIBLE     = 2'd2,
        REGION_FRONT_PORCH = 2'd3
    } t_region;

    localparam int unsigned APB_ADDR_BITS = 5;
    localparam int unsigned APB_DATA_BITS = 32;

    localparam int unsigned RST_H_TOTAL       = 800;
    localparam int unsigned RST_H_SYNC_WIDTH  = 96;
    localparam int unsigned RST_V_SYNC_WIDTH  = 2;
    localparam int unsigned RST_V_BP_LINES    = 33;
    localparam int unsigned RST_V_VISIBLE     = 480;
    localparam int unsigned RST_V_FP_LINES    = 10;

endpackage

>>> hdl/crt_sync_timing_generator_top.sv
// ----------------------------------------------------------------------------
// CRT sync timing generator
// Raster counters with region, visible row and sync level decode per tick.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_advance
// result    out        o_valid / i_stall  o_column, o_line_region, o_visible_row,
//                                         o_sync_level, o_vsync_pin, o_frame_count
// config    in         APB psel/penable   paddr, pwdata, prdata
//
// One tick is accepted per clock while o_stall is low; the counters register it and
// the result register then takes its decode onto the outputs, so a continuous
// stream runs at one item per cycle while i_stall is low.
// A stalled result holds while one more tick is still taken into the counters.
// Reset is synchronous and active low and restores the default 640x480 timing.
// ----------------------------------------------------------------------------
module crt_sync_timing_generator_top #(
    parameter int unsigned H_COUNT_BITS = 12,
    parameter int unsigned V_COUNT_BITS = 11
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_advance,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [H_COUNT_BITS-1:0]              o_column,
    output logic [1:0]                           o_line_region,
    output logic [V_COUNT_BITS-1:0]              o_visible_row,
    output logic                                 o_sync_level,
    output logic                                 o_vsync_pin,
    output logic [31:0]                          o_frame_count,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [crtstg_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [crtstg_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [crtstg_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                 pready
);
    import crtstg_pkg::*;

    logic [H_COUNT_BITS-1:0] h_total;
    logic [H_COUNT_BITS-1:0] h_sync_width;
    logic [V_COUNT_BITS-1:0] v_sync_width;
    logic [V_COUNT_BITS-1:0] v_bp_lines;
    logic [V_COUNT_BITS-1:0] v_visible;
    logic [V_COUNT_BITS-1:0] v_fp_lines;
    t_sync_mode              sync_mode;
    logic [1:0]              sync_polarity;
    logic                    pend;
    logic                    move;
    logic                    accept;
    logic [H_COUNT_BITS-1:0] cnt_column;
    logic [V_COUNT_BITS+1:0] cnt_line;
    logic [31:0]             cnt_frames;

    assign o_stall = pend && !move;
    assign accept  = i_valid && !o_stall;

    crtstg_cfg_regs #(
        .H_COUNT_BITS (H_COUNT_BITS),
        .V_COUNT_BITS (V_COUNT_BITS)
    ) u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_h_total       (h_total),
        .o_h_sync_width  (h_sync_width),
        .o_v_sync_width  (v_sync_width),
        .o_v_bp_lines    (v_bp_lines),
        .o_v_visible     (v_visible),
        .o_v_fp_lines    (v_fp_lines),
        .o_sync_mode     (sync_mode),
        .o_sync_polarity (sync_polarity)
    );

    crtstg_counters #(
        .H_COUNT_BITS (H_COUNT_BITS),
        .V_COUNT_BITS (V_COUNT_BITS)
    ) u_cnt (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_advance       (i_advance),
        .i_move          (move),
        .i_h_total       (h_total),
        .i_v_sync_width  (v_sync_width),
        .i_v_bp_lines    (v_bp_lines),
        .i_v_visible     (v_visible),
        .i_v_fp_lines    (v_fp_lines),
        .o_pend          (pend),
        .o_column        (cnt_column),
        .o_line          (cnt_line),
        .o_frames        (cnt_frames)
    );

    crtstg_decode #(
        .H_COUNT_BITS (H_COUNT_BITS),
        .V_COUNT_BITS (V_COUNT_BITS)
    ) u_dec (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pend          (pend),
        .i_stall         (i_stall),
        .i_column        (cnt_column),
        .i_line          (cnt_line),
        .i_frames        (cnt_frames),
        .i_h_sync_width  (h_sync_width),
        .i_v_sync_width  (v_sync_width),
        .i_v_bp_lines    (v_bp_lines),
        .i_v_visible     (v_visible),
        .i_sync_mode     (sync_mode),
        .i_sync_polarity (sync_polarity),
        .o_move          (move),
        .o_valid         (o_valid),
        .o_column        (o_column),
        .o_line_region   (o_line_region),
        .o_visible_row   (o_visible_row),
        .o_sync_level    (o_sync_level),
        .o_vsync_pin     (o_vsync_pin),
        .o_frame_count   (o_frame_count)
    );

endmodule

>>> hdl/crtstg_cfg_regs.sv
// ----------------------------------------------------------------------------
// CRT sync timing generator configuration registers
// APB register file holding the raster geometry, sync mode and polarity.
// ----------------------------------------------------------------------------
module crtstg_cfg_regs #(
    parameter int unsigned H_COUNT_BITS = 12,
    parameter int unsigned V_COUNT_BITS = 11
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [crtstg_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [crtstg_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [crtstg_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                pready,
    output logic [H_COUNT_BITS-1:0]             o_h_total,
    output logic [H_COUNT_BITS-1:0]             o_h_sync_width,
    output logic [V_COUNT_BITS-1:0]             o_v_sync_width,
    output logic [V_COUNT_BITS-1:0]             o_v_bp_lines,
    output logic [V_COUNT_BITS-1:0]             o_v_visible,
    output logic [V_COUNT_BITS-1:0]             o_v_fp_lines,
    output crtstg_pkg::t_sync_mode              o_sync_mode,
    output logic [1:0]                          o_sync_polarity
);
    import crtstg_pkg::*;

    localparam int unsigned DW = APB_DATA_BITS;

    logic [H_COUNT_BITS-1:0] r_h_total;
    logic [H_COUNT_BITS-1:0] r_h_sync_width;
    logic [V_COUNT_BITS-1:0] r_v_sync_width;
    logic [V_COUNT_BITS-1:0] r_v_bp_lines;
    logic [V_COUNT_BITS-1:0] r_v_visible;
    logic [V_COUNT_BITS-1:0] r_v_fp_lines;
    t_sync_mode              r_sync_mode;
    logic [1:0]              r_sync_polarity;
    t_reg_idx                reg_idx;
    logic                    wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_BITS-1:2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_total       <= H_COUNT_BITS'(RST_H_TOTAL);
            r_h_sync_width  <= H_COUNT_BITS'(RST_H_SYNC_WIDTH);
            r_v_sync_width  <= V_COUNT_BITS'(RST_V_SYNC_WIDTH);
            r_v_bp_lines    <= V_COUNT_BITS'(RST_V_BP_LINES);
            r_v_visible     <= V_COUNT_BITS'(RST_V_VISIBLE);
            r_v_fp_lines    <= V_COUNT_BITS'(RST_V_FP_LINES);
            r_sync_mode     <= SYNC_SEPARATE;
            r_sync_polarity <= 2'b00;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_H_TOTAL:       r_h_total       <= pwdata[H_COUNT_BITS-1:0];
                REG_H_SYNC_WIDTH:  r_h_sync_width  <= pwdata[H_COUNT_BITS-1:0];
                REG_V_SYNC_WIDTH:  r_v_sync_width  <= pwdata[V_COUNT_BITS-1:0];
                REG_V_BP_LINES:    r_v_bp_lines    <= pwdata[V_COUNT_BITS-1:0];
                REG_V_VISIBLE:     r_v_visible     <= pwdata[V_COUNT_BITS-1:0];
                REG_V_FP_LINES:    r_v_fp_lines    <= pwdata[V_COUNT_BITS-1:0];
                REG_SYNC_MODE:     r_sync_mode     <= t_sync_mode'(pwdata[1:0]);
                REG_SYNC_POLARITY: r_sync_polarity <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_H_TOTAL:       prdata = DW'(r_h_total);
            REG_H_SYNC_WIDTH:  prdata = DW'(r_h_sync_width);
            REG_V_SYNC_WIDTH:  prdata = DW'(r_v_sync_width);
            REG_V_BP_LINES:    prdata = DW'(r_v_bp_lines);
            REG_V_VISIBLE:     prdata = DW'(r_v_visible);
            REG_V_FP_LINES:    prdata = DW'(r_v_fp_lines);
            REG_SYNC_MODE:     prdata = DW'(r_sync_mode);
            REG_SYNC_POLARITY: prdata = DW'(r_sync_polarity);
            default:           prdata = '0;
        endcase
    end

    assign o_h_total       = r_h_total;
    assign o_h_sync_width  = r_h_sync_width;
    assign o_v_sync_width  = r_v_sync_width;
    assign o_v_bp_lines    = r_v_bp_lines;
    assign o_v_visible     = r_v_visible;
    assign o_v_fp_lines    = r_v_fp_lines;
    assign o_sync_mode     = r_sync_mode;
    assign o_sync_polarity = r_sync_polarity;

endmodule

>>> hdl/crtstg_counters.sv
// ----------------------------------------------------------------------------
// CRT sync timing generator raster counters
// Column, line and frame counters, stepped once per accepted tick with i_advance set.
// ----------------------------------------------------------------------------
module crtstg_counters #(
    parameter int unsigned H_COUNT_BITS = 12,
    parameter int unsigned V_COUNT_BITS = 11
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic                      i_advance,
    input  logic                      i_move,
    input  logic [H_COUNT_BITS-1:0]   i_h_total,
    input  logic [V_COUNT_BITS-1:0]   i_v_sync_width,
    input  logic [V_COUNT_BITS-1:0]   i_v_bp_lines,
    input  logic [V_COUNT_BITS-1:0]   i_v_visible,
    input  logic [V_COUNT_BITS-1:0]   i_v_fp_lines,
    output logic                      o_pend,
    output logic [H_COUNT_BITS-1:0]   o_column,
    output logic [V_COUNT_BITS+1:0]   o_line,
    output logic [31:0]               o_frames
);
    import crtstg_pkg::*;

    localparam int unsigned LW = V_COUNT_BITS + 2;

    logic                    r_pend;
    logic [H_COUNT_BITS-1:0] r_column;
    logic [LW-1:0]           r_line;
    logic [31:0]             r_frames;
    logic [H_COUNT_BITS-1:0] n_column;
    logic [LW-1:0]           n_line;
    logic [31:0]             n_frames;
    logic [H_COUNT_BITS:0]   col_inc;
    logic [LW:0]             line_inc;
    logic [LW-1:0]           v_total;

    assign v_total  = LW'(i_v_sync_width) + LW'(i_v_bp_lines)
                    + LW'(i_v_visible) + LW'(i_v_fp_lines);
    assign col_inc  = {1'b0, r_column} + 1'b1;
    assign line_inc = {1'b0, r_line} + 1'b1;

    // Compares use >= so that a counter left beyond a lowered total wraps.
    always_comb begin
        n_column = r_column;
        n_line   = r_line;
        n_frames = r_frames;
        if (i_advance) begin
            if (col_inc >= {1'b0, i_h_total}) begin
                n_column = '0;
                if (line_inc >= {1'b0, v_total}) begin
                    n_line   = '0;
                    n_frames = r_frames + 32'd1;
                end else begin
                    n_line = line_inc[LW-1:0];
                end
            end else begin
                n_column = col_inc[H_COUNT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 1'b0;
            r_column <= '0;
            r_line   <= '0;
            r_frames <= '0;
        end else begin
            if (i_accept) begin
                r_pend   <= 1'b1;
                r_column <= n_column;
                r_line   <= n_line;
                r_frames <= n_frames;
            end else if (i_move) begin
                r_pend <= 1'b0;
            end
        end
    end

    assign o_pend   = r_pend;
    assign o_column = r_column;
    assign o_line   = r_line;
    assign o_frames = r_frames;

endmodule

>>> hdl/crtstg_decode.sv
// ----------------------------------------------------------------------------
// CRT sync timing generator result stage
// Decodes region, visible row and sync levels into the result register.
// ----------------------------------------------------------------------------
module crtstg_decode #(
    parameter int unsigned H_COUNT_BITS = 12,
    parameter int unsigned V_COUNT_BITS = 11
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_pend,
    input  logic                      i_stall,
    input  logic [H_COUNT_BITS-1:0]   i_column,
    input  logic [V_COUNT_BITS+1:0]   i_line,
    input  logic [31:0]               i_frames,
    input  logic [H_COUNT_BITS-1:0]   i_h_sync_width,
    input  logic [V_COUNT_BITS-1:0]   i_v_sync_width,
    input  logic [V_COUNT_BITS-1:0]   i_v_bp_lines,
    input  logic [V_COUNT_BITS-1:0]   i_v_visible,
    input  crtstg_pkg::t_sync_mode    i_sync_mode,
    input  logic [1:0]                i_sync_polarity,
    output logic                      o_move,
    output logic                      o_valid,
    output logic [H_COUNT_BITS-1:0]   o_column,
    output logic [1:0]                o_line_region,
    output logic [V_COUNT_BITS-1:0]   o_visible_row,
    output logic                      o_sync_level,
    output logic                      o_vsync_pin,
    output logic [31:0]               o_frame_count
);
    import crtstg_pkg::*;

    localparam int unsigned LW = V_COUNT_BITS + 2;

    logic                    r_valid;
    logic [H_COUNT_BITS-1:0] r_column;
    t_region                 r_region;
    logic [V_COUNT_BITS-1:0] r_row;
    logic                    r_sync;
    logic                    r_vsync;
    logic [31:0]             r_frames;
    t_region                 n_region;
    logic [V_COUNT_BITS-1:0] n_row;
    logic                    n_sync;
    logic                    n_vsync;
    logic [LW-1:0]           end_sync;
    logic [LW-1:0]           end_back;
    logic [LW-1:0]           end_vis;
    logic [LW-1:0]           row_full;
    logic                    h_act;
    logic                    v_act;
    logic                    hs;
    logic                    vs;

    assign end_sync = LW'(i_v_sync_width);
    assign end_back = end_sync + LW'(i_v_bp_lines);
    assign end_vis  = end_back + LW'(i_v_visible);
    assign row_full = i_line - end_back;

    assign h_act = i_sync_polarity[0];
    assign v_act = i_sync_polarity[1];
    assign hs    = (i_column < i_h_sync_width) ? h_act : !h_act;
    assign vs    = (i_line < end_sync) ? v_act : !v_act;

    always_comb begin
        n_row = '0;
        priority if (i_line < end_sync) begin
            n_region = REGION_VSYNC;
        end else if (i_line < end_back) begin
            n_region = REGION_BACK_PORCH;
        end else if (i_line < end_vis) begin
            n_region = REGION_VISIBLE;
            n_row    = row_full[V_COUNT_BITS-1:0];
        end else begin
            n_region = REGION_FRONT_PORCH;
        end
    end

    always_comb begin
        unique case (i_sync_mode)
            SYNC_SEPARATE: n_sync = hs;
            SYNC_COMP_XOR: n_sync = hs ^ vs;
            SYNC_COMP_AND: n_sync = hs & vs;
            SYNC_DISABLED: n_sync = !h_act;
            default:       n_sync = !h_act;
        endcase
        n_vsync = (i_sync_mode == SYNC_SEPARATE) ? vs : !v_act;
    end

    // The pending position moves here when the result register is free or drains.
    assign o_move = i_pend && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_move) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_move) begin
            r_column <= i_column;
            r_region <= n_region;
            r_row    <= n_row;
            r_sync   <= n_sync;
            r_vsync  <= n_vsync;
            r_frames <= i_frames;
        end
    end

    assign o_valid       = r_valid;
    assign o_column      = r_column;
    assign o_line_region = r_region;
    assign o_visible_row = r_row;
    assign o_sync_level  = r_sync;
    assign o_vsync_pin   = r_vsync;
    assign o_frame_count = r_frames;

endmodule

>>> hdl/crtstg_checker.sv
// ----------------------------------------------------------------------------
// CRT sync timing generator port checker
// Concurrent checks on the top-level ports, attached by a bind statement.
// ----------------------------------------------------------------------------
module crtstg_checker #(
    parameter int unsigned H_COUNT_BITS = 12,
    parameter int unsigned V_COUNT_BITS = 11
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic [H_COUNT_BITS-1:0] o_column,
    input logic [1:0]              o_line_region,
    input logic [V_COUNT_BITS-1:0] o_visible_row,
    input logic [31:0]             o_frame_count
);
    import crtstg_pkg::*;

    // A result waiting on a stall keeps its position.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_column) && $stable(o_frame_count))
        else $error("stalled result changed");

    a_row_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_line_region != REGION_VISIBLE) |-> (o_visible_row == '0))
        else $error("visible row nonzero outside the visible region");

    // Consecutive results are one tick apart, so frames step by at most one.
    a_frame_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall ##1 o_valid |->
            (o_frame_count == $past(o_frame_count)) ||
            (o_frame_count == $past(o_frame_count) + 32'd1))
        else $error("frame count jumped between results");

    // The column holds, steps by one or wraps to zero between results.
    a_column_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall ##1 o_valid |->
            (o_column == $past(o_column)) ||
            (o_column == $past(o_column) + 1'b1) ||
            (o_column == '0))
        else $error("column moved by more than one pixel");

endmodule

bind crt_sync_timing_generator_top crtstg_checker #(
    .H_COUNT_BITS (H_COUNT_BITS),
    .V_COUNT_BITS (V_COUNT_BITS)
) u_crtstg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_column      (o_column),
    .o_line_region (o_line_region),
    .o_visible_row (o_visible_row),
    .o_frame_count (o_frame_count)
);
